// ----- rtl/pctd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_pkg
// Shared types, the escape character code and the hex digit decoder for the
// percent-escape decoder.
// ----------------------------------------------------------------------------
package pctd_pkg;

  // ASCII percent sign, the escape introducer
  localparam logic [7:0] CHAR_PCT = 8'h25;

  // Largest number of output bytes one input byte can cause
  localparam int unsigned MAX_RES = 3;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);

  // Decoded hex digit: valid flag and its 4-bit value
  typedef struct packed {
    logic       valid;
    logic [3:0] nib;
  } hex_t;

  // Output bytes produced for one accepted request
  typedef struct packed {
    logic [CNT_W-1:0] cnt;       // number of bytes, 0..MAX_RES
    logic [7:0]       b0;
    logic [7:0]       b1;
    logic [7:0]       b2;
    logic             last_end;  // request carried the end-of-string flag
  } pctd_res_t;

  // 0-9, A-F, a-f to a nibble; anything else is flagged not valid
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.valid = 1'b1;
    h.nib   = c[3:0];
    if (c inside {[8'h30:8'h39]}) begin
      h.nib = c[3:0];
    end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
      h.nib = 4'(c[3:0] + 4'd9);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

// ----- rtl/percent_escape_decoder.sv -----
`timescale 1ns / 1ps
// First output byte of an input byte appears in the cycle after it is taken.
// Throughput: one input byte per cycle while each causes at most one output
//   byte and the output is not stalled; a byte causing more holds the input
//   stalled until the single-byte output port takes its last byte.
// Reset: synchronous, active low; scanner returns idle with no pending escape.
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Streaming percent-escape decoder: '%' plus two hex digits becomes one byte,
// broken or zero escapes pass through literally.
// ----------------------------------------------------------------------------
module percent_escape_decoder
  import pctd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_run_last,
  output logic       out_string_done
);

  pctd_res_t res;
  logic      ready;
  logic      in_accept;

  assign in_stall  = !ready;
  assign in_accept = in_valid && ready;

  // Scanner state and byte generation
  pctd_scan u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (in_accept),
    .char_in    (in_char_in),
    .string_end (in_string_end),
    .res        (res)
  );

  // Result register and output serializer
  pctd_outbuf u_outbuf (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .res             (res),
    .ready           (ready),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

`ifndef ASSERT_OFF
  // end of string is flagged only on the last byte of a request
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_done |-> out_run_last)
    else $error("string_done without run_last");
`endif

endmodule

// ----- rtl/pctd_scan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_scan
// Escape scanner: holds the scan mode and the first digit of a pending
// escape, and works out the output bytes for the request being accepted.
// ----------------------------------------------------------------------------
module pctd_scan
  import pctd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] char_in,
  input  logic       string_end,
  output pctd_res_t  res
);

  typedef enum logic [1:0] {
    SCAN_IDLE = 2'd0,
    SCAN_PCT  = 2'd1,
    SCAN_DIG  = 2'd2
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] held_r, held_nxt;

  hex_t       hc, hh;
  logic       fresh_emit;
  logic [7:0] dec_val;

  assign hc      = hex_decode(char_in);
  assign hh      = hex_decode(held_r);
  assign dec_val = {hh.nib, hc.nib};
  // A fresh scan emits the byte unless it opens a new escape
  assign fresh_emit = !((char_in == CHAR_PCT) && !string_end);

  // Next mode and output bytes
  always_comb begin
    mode_nxt     = mode_r;
    held_nxt     = held_r;
    res.cnt      = '0;
    res.b0       = char_in;
    res.b1       = char_in;
    res.b2       = char_in;
    res.last_end = string_end;
    case (mode_r)
      SCAN_PCT: begin
        if (hc.valid) begin
          if (string_end) begin
            res.cnt = CNT_W'(2);
            res.b0  = CHAR_PCT;
          end else begin
            mode_nxt = SCAN_DIG;
            held_nxt = char_in;
          end
        end else begin
          res.b0 = CHAR_PCT;
          if (fresh_emit) begin
            res.cnt  = CNT_W'(2);
            mode_nxt = SCAN_IDLE;
            held_nxt = '0;
          end else begin
            res.cnt  = CNT_W'(1);
            mode_nxt = SCAN_PCT;
          end
        end
      end
      SCAN_DIG: begin
        if (hh.valid && hc.valid && (dec_val != 8'h00)) begin
          res.cnt  = CNT_W'(1);
          res.b0   = dec_val;
          mode_nxt = SCAN_IDLE;
          held_nxt = '0;
        end else begin
          res.b0 = CHAR_PCT;
          res.b1 = held_r;
          if (fresh_emit) begin
            res.cnt  = CNT_W'(3);
            mode_nxt = SCAN_IDLE;
            held_nxt = '0;
          end else begin
            res.cnt  = CNT_W'(2);
            mode_nxt = SCAN_PCT;
          end
        end
      end
      default: begin
        if (fresh_emit) begin
          res.cnt  = CNT_W'(1);
          mode_nxt = SCAN_IDLE;
          held_nxt = '0;
        end else begin
          mode_nxt = SCAN_PCT;
        end
      end
    endcase
    // End of string always leaves the scanner idle
    if (string_end) begin
      mode_nxt = SCAN_IDLE;
      held_nxt = '0;
    end
  end

  // State update on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= SCAN_IDLE;
      held_r <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      held_r <= held_nxt;
    end
  end

`ifndef ASSERT_OFF
  // a finished string leaves no escape pending
  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept && string_end |=> mode_r == SCAN_IDLE)
    else $error("scanner not idle after end of string");

  // a held first digit is always a hex digit
  a_held_hex: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r == SCAN_DIG |-> hh.valid)
    else $error("held digit is not hex");
`endif

endmodule

// ----- rtl/pctd_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pctd_outbuf
// Result register: holds up to three output bytes of one request and
// shifts them out one per accepted output request.
// ----------------------------------------------------------------------------
module pctd_outbuf
  import pctd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  pctd_res_t  res,
  output logic       ready,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_char_out,
  output logic       out_run_last,
  output logic       out_string_done
);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       byte_r [MAX_RES];
  logic             end_r;
  logic             take, load, last;

  assign out_valid       = (cnt_r != '0);
  assign take            = out_valid && !out_stall;
  assign last            = (cnt_r == CNT_W'(1));
  assign ready           = (cnt_r == '0) || (last && !out_stall);
  assign load            = accept && (res.cnt != '0);
  assign out_char_out    = byte_r[0];
  assign out_run_last    = last;
  assign out_string_done = last && end_r;

  // Occupancy count
  always_comb begin
    cnt_nxt = cnt_r;
    if (load) begin
      cnt_nxt = res.cnt;
    end else if (take) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Byte shift line, loaded with a whole request's bytes
  always_ff @(posedge clk) begin
    if (load) begin
      byte_r[0] <= res.b0;
      byte_r[1] <= res.b1;
      byte_r[2] <= res.b2;
      end_r     <= res.last_end;
    end else if (take) begin
      byte_r[0] <= byte_r[1];
      byte_r[1] <= byte_r[2];
    end
  end

`ifndef ASSERT_OFF
  // new bytes only arrive once the old ones are gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (cnt_r == '0) || (last && take))
    else $error("result register overwritten");

  // a taken byte that is not the last is followed by the next one
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    take && !last |=> out_valid)
    else $error("result bytes lost");
`endif

endmodule

// ----- bench/percent_escape_decoder_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// percent_escape_decoder_test
// Self-checking bench for the streaming percent-escape decoder. A short table
// of directed bytes covers the escape corner cases. Random strings follow:
// plain bytes and well-formed escapes with random content, plus broken ones.
// Every output byte is checked against the table or the in-bench decoder, with
// random idling on both sides, a long output hold-off and a full drain mid-run.
// ----------------------------------------------------------------------------
module percent_escape_decoder_test;
  import pctd_pkg::*;

  localparam int NO_DIGIT   = 16;
  localparam int DIR_ROWS   = 25;
  localparam int RAND_ITEMS = 285;
  localparam int HOLD_LEN   = 60;

  typedef enum logic [1:0] {
    SCAN_IDLE  = 2'd0,
    SCAN_PCT   = 2'd1,
    SCAN_DIGIT = 2'd2
  } scan_e;

  // one decoded output byte with its flags
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       done;
  } out_byte_t;

  // directed row; when typed is set, n and b0..b2 hold the expected bytes
  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_char_in = 8'h00;
  logic       in_string_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_char_out;
  logic       out_run_last;
  logic       out_string_done;

  // bench-side decoder state
  scan_e      scan_mode = SCAN_IDLE;
  logic [7:0] held_digit = 8'h00;
  logic [7:0] decoded_bytes [$];
  out_byte_t  expect_q [$];

  int  errors = 0;
  int  items_sent = 0;
  int  bytes_seen = 0;
  int  strings_seen = 0;
  int  escapes_decoded = 0;
  int  src_idle_pct = 20;
  int  snk_idle_pct = 20;
  bit  hold_req = 1'b0;
  int  hold_left = 0;

  dir_row_t dir_rows [0:DIR_ROWS-1];

  percent_escape_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_char_in      (in_char_in),
    .in_string_end   (in_string_end),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_char_out    (out_char_out),
    .out_run_last    (out_run_last),
    .out_string_done (out_string_done)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // digit value, or NO_DIGIT for anything that is not hex
  function automatic int hex_nibble(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - 8'h30);
    if (c >= "A" && c <= "F") return int'(c - 8'h41) + 10;
    if (c >= "a" && c <= "f") return int'(c - 8'h61) + 10;
    return NO_DIGIT;
  endfunction

  // scan a byte as if no escape were pending
  function automatic void rescan(input logic [7:0] c, input logic fin);
    if (c == CHAR_PCT && !fin) begin
      scan_mode = SCAN_PCT;
    end else begin
      decoded_bytes.push_back(c);
      scan_mode  = SCAN_IDLE;
      held_digit = 8'h00;
    end
  endfunction

  // advance the decoder by one byte; queue its output when record is set
  function automatic void decode_byte(input logic [7:0] c, input logic fin, input bit record);
    int hi;
    int lo;
    int val;
    hi  = hex_nibble(held_digit);
    lo  = hex_nibble(c);
    val = (hi % 16) * 16 + (lo % 16);
    decoded_bytes.delete();
    case (scan_mode)
      SCAN_PCT: begin
        if (lo != NO_DIGIT && fin) begin
          decoded_bytes.push_back(CHAR_PCT);
          decoded_bytes.push_back(c);
        end else if (lo != NO_DIGIT) begin
          held_digit = c;
          scan_mode  = SCAN_DIGIT;
        end else begin
          decoded_bytes.push_back(CHAR_PCT);
          rescan(c, fin);
        end
      end
      SCAN_DIGIT: begin
        if (hi != NO_DIGIT && lo != NO_DIGIT && val != 0) begin
          decoded_bytes.push_back(8'(val));
          scan_mode  = SCAN_IDLE;
          held_digit = 8'h00;
          escapes_decoded++;
        end else begin
          decoded_bytes.push_back(CHAR_PCT);
          decoded_bytes.push_back(held_digit);
          rescan(c, fin);
        end
      end
      default: rescan(c, fin);
    endcase
    if (fin) begin
      scan_mode  = SCAN_IDLE;
      held_digit = 8'h00;
    end
    if (record) begin
      foreach (decoded_bytes[i]) begin
        expect_q.push_back('{ch:   decoded_bytes[i],
                             last: (i == decoded_bytes.size() - 1),
                             done: (i == decoded_bytes.size() - 1) && fin});
      end
    end
  endfunction

  // offer one request, with random idle cycles first; returns once taken
  task automatic offer_byte(input logic [7:0] c, input logic fin);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_char_in    <= c;
    in_string_end <= fin;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (expect_q.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (expect_q.size() != 0) begin
      errors++;
      $display("%0t: %0d output bytes never arrived", $time, expect_q.size());
    end
  endtask

  function automatic logic [7:0] rand_hex();
    int idx;
    idx = $urandom_range(21);
    if (idx < 10) return 8'(8'h30 + idx);
    if (idx < 16) return 8'(8'h61 + idx - 10);
    return 8'(8'h41 + idx - 16);
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (hex_nibble(c) != NO_DIGIT);
    return c;
  endfunction

  // random strings until the random request count reaches limit
  task automatic run_strings(input int limit);
    logic [7:0] str [$];
    int tokens;
    int kind;
    bit cut;
    while (items_sent - DIR_ROWS < limit) begin
      str.delete();
      cut    = 1'b0;
      tokens = $urandom_range(1, 6);
      for (int t = 0; t < tokens && !cut; t++) begin
        kind = $urandom_range(99);
        if (kind < 35) begin
          // plain byte, any value
          str.push_back(8'($urandom_range(255)));
        end else if (kind < 42) begin
          // zero-valued escape
          str.push_back(CHAR_PCT);
          str.push_back("0");
          str.push_back("0");
        end else if (kind < 75) begin
          str.push_back(CHAR_PCT);
          str.push_back(rand_hex());
          str.push_back(rand_hex());
        end else if (kind < 84) begin
          // bad second digit, sometimes a new '%'
          str.push_back(CHAR_PCT);
          str.push_back(rand_hex());
          str.push_back($urandom_range(1) ? CHAR_PCT : rand_non_hex());
        end else if (kind < 92) begin
          // bad first digit
          str.push_back(CHAR_PCT);
          str.push_back($urandom_range(1) ? CHAR_PCT : rand_non_hex());
        end else begin
          // string cut short inside an escape
          str.push_back(CHAR_PCT);
          if ($urandom_range(1)) str.push_back(rand_hex());
          cut = 1'b1;
        end
      end
      foreach (str[i]) begin
        offer_byte(str[i], i == str.size() - 1);
        decode_byte(str[i], i == str.size() - 1, 1'b1);
      end
    end
  endtask

  // receiver: check each taken output byte, then choose the next stall
  always begin
    @(posedge clk);
    if (rst_n && out_valid && !out_stall) begin
      bytes_seen++;
      if (out_string_done) strings_seen++;
      if (expect_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected output byte, got char %02h last %0b done %0b",
                 $time, out_char_out, out_run_last, out_string_done);
      end else begin
        out_byte_t exp_b;
        exp_b = expect_q.pop_front();
        if (out_char_out !== exp_b.ch || out_run_last !== exp_b.last ||
            out_string_done !== exp_b.done) begin
          errors++;
          $display("%0t: mismatch, expected char %02h last %0b done %0b, got char %02h last %0b done %0b",
                   $time, exp_b.ch, exp_b.last, exp_b.done,
                   out_char_out, out_run_last, out_string_done);
        end
      end
    end
    // long hold-off on request, else random stalls
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_LEN;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < snk_idle_pct);
    end
  end

  initial begin
    //            ch        fin typed n  b0        b1        b2
    dir_rows = '{'{"A",      0, 1,  1, "A",      8'h00,    8'h00},
                 '{8'h00,    0, 1,  1, 8'h00,    8'h00,    8'h00},
                 '{8'hFF,    1, 1,  1, 8'hFF,    8'h00,    8'h00},
                 '{CHAR_PCT, 0, 1,  0, 8'h00,    8'h00,    8'h00},
                 '{"4",      0, 1,  0, 8'h00,    8'h00,    8'h00},
                 '{"1",      0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{CHAR_PCT, 0, 1,  0, 8'h00,    8'h00,    8'h00},
                 '{"0",      0, 1,  0, 8'h00,    8'h00,    8'h00},
                 '{"0",      0, 1,  3, CHAR_PCT, "0",      "0"},
                 '{CHAR_PCT, 0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"f",      0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"F",      0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{CHAR_PCT, 0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"G",      0, 1,  2, CHAR_PCT, "G",      8'h00},
                 '{CHAR_PCT, 0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"a",      0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{CHAR_PCT, 0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"2",      0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"5",      0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{CHAR_PCT, 1, 1,  1, CHAR_PCT, 8'h00,    8'h00},
                 '{CHAR_PCT, 0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"3",      1, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{CHAR_PCT, 0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"4",      0, 0,  0, 8'h00,    8'h00,    8'h00},
                 '{"1",      1, 0,  0, 8'h00,    8'h00,    8'h00}};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed table
    foreach (dir_rows[r]) begin
      offer_byte(dir_rows[r].ch, dir_rows[r].fin);
      if (dir_rows[r].typed) begin
        for (int k = 0; k < int'(dir_rows[r].n); k++) begin
          expect_q.push_back('{ch:   (k == 0) ? dir_rows[r].b0 :
                                     (k == 1) ? dir_rows[r].b1 : dir_rows[r].b2,
                               last: (k == int'(dir_rows[r].n) - 1),
                               done: (k == int'(dir_rows[r].n) - 1) && dir_rows[r].fin});
        end
        decode_byte(dir_rows[r].ch, dir_rows[r].fin, 1'b0);
      end else begin
        decode_byte(dir_rows[r].ch, dir_rows[r].fin, 1'b1);
      end
    end

    // random strings with idling on both sides
    run_strings(110);

    // output held off while requests keep coming
    src_idle_pct = 0;
    hold_req     = 1'b1;
    run_strings(150);

    // sender pauses until every output byte is back
    in_valid <= 1'b0;
    wait_drained();

    // back to back, no idling anywhere
    snk_idle_pct = 0;
    run_strings(220);

    src_idle_pct = 20;
    snk_idle_pct = 20;
    run_strings(RAND_ITEMS);

    in_valid <= 1'b0;
    wait_drained();
    repeat (8) @(posedge clk);

    $display("Sent %0d requests; checked %0d output bytes over %0d strings,", items_sent,
             bytes_seen, strings_seen);
    $display("%0d escapes decoded, including hold-off and drain phases.", escapes_decoded);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Timeout: %0d output bytes still expected", expect_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
